### src/epipolar_distance_check_assert.svh
// assertion macros shared by the epipolar distance check modules
`ifndef EPIPOLAR_DISTANCE_CHECK_ASSERT_SVH
`define EPIPOLAR_DISTANCE_CHECK_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define EDC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edc assertion failed");

// next-cycle implication, ignored while reset is high
`define EDC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edc assertion failed");

`endif

### src/edc_pkg.sv
// types and constants of the epipolar distance check
package edc_pkg;

   localparam int PointWidth       = 16;
   localparam int DistWidth        = 16;
   localparam int RootWidth        = 17;
   localparam int RowWidth         = 63;
   localparam int CsrIndexWidth    = 2;
   localparam int QueueDepth       = 4;
   localparam int CoefWidthDefault = 21;
   localparam int FracBitsDefault  = 4;
   localparam logic [DistWidth-1:0] DistLimitReset = 16'd16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ROW_ZERO,
      CSR_ROW_ONE,
      CSR_ROW_TWO,
      CSR_DIST_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [PointWidth-1:0] first_x;
      logic [PointWidth-1:0] first_y;
      logic [PointWidth-1:0] second_x;
      logic [PointWidth-1:0] second_y;
   } edc_req_type;

   typedef struct packed {
      logic [DistWidth-1:0] line_distance;
      logic                 on_line;
      logic                 degenerate;
      logic                 saturated;
   } edc_rsp_type;

endpackage

### src/edc_front.sv
// front end: takes correspondences and forms the epipolar line coefficients
module edc_front
   import edc_pkg::*;
#(
   parameter int COEF_WIDTH = CoefWidthDefault,
   parameter int FRAC_BITS  = FracBitsDefault,
   parameter int LW         = COEF_WIDTH + PointWidth + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  edc_req_type                req_data,
   output logic                       req_full,
   input  logic [2:0][RowWidth-1:0]   rows,
   input  logic                       q_full,
   output logic                       q_push,
   output logic [3*LW+2*PointWidth-1:0] q_data
);

   localparam int PW1 = COEF_WIDTH + PointWidth + 1;

   logic                         adv;
   logic                         f1_vld_ff, f2_vld_ff;
   logic signed [PW1-1:0]        px_ff [3];
   logic signed [PW1-1:0]        py_ff [3];
   logic signed [COEF_WIDTH-1:0] pz_ff [3];
   logic signed [PW1-1:0]        px_in [3];
   logic signed [PW1-1:0]        py_in [3];
   logic signed [COEF_WIDTH-1:0] pz_in [3];
   logic [PointWidth-1:0]        x2_f1_ff, y2_f1_ff, x2_f2_ff, y2_f2_ff;
   logic signed [LW-1:0]         line_ff [3];
   logic signed [LW-1:0]         line_in [3];

   assign adv      = !f2_vld_ff || !q_full;
   assign req_full = !adv;
   assign q_push   = f2_vld_ff;
   assign q_data   = {line_ff[0], line_ff[1], line_ff[2], x2_f2_ff, y2_f2_ff};

   always_comb begin
      logic signed [COEF_WIDTH-1:0] cx, cy;
      logic signed [PointWidth:0]   sx, sy;
      sx = signed'({1'b0, req_data.first_x});
      sy = signed'({1'b0, req_data.first_y});
      for (int r = 0; r < 3; r++) begin
         cx       = signed'(rows[r][COEF_WIDTH-1:0]);
         cy       = signed'(rows[r][2*COEF_WIDTH-1:COEF_WIDTH]);
         pz_in[r] = signed'(rows[r][3*COEF_WIDTH-1:2*COEF_WIDTH]);
         px_in[r] = PW1'(cx) * PW1'(sx);
         py_in[r] = PW1'(cy) * PW1'(sy);
      end
      for (int r = 0; r < 3; r++) begin
         line_in[r] = LW'(px_ff[r]) + LW'(py_ff[r]) + (LW'(pz_ff[r]) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= req_push;
         f2_vld_ff <= f1_vld_ff;
      end
      if (adv) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         x2_f1_ff <= req_data.second_x;
         y2_f1_ff <= req_data.second_y;
         line_ff  <= line_in;
         x2_f2_ff <= x2_f1_ff;
         y2_f2_ff <= y2_f1_ff;
      end
   end

endmodule

### src/edc_queue.sv
// small queue between the front end and the distance pipeline
module edc_queue
   import edc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == PTW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTW'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == PTW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTW'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - CW'(1);
         end
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

`include "epipolar_distance_check_assert.svh"
   `EDC_ASSERT_IMP(a_q_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `EDC_ASSERT_NEXT(a_q_count_up, clock, reset, push_ok && !pop_ok, count_ff == $past(count_ff) + CW'(1))

endmodule

### src/edc_back.sv
// distance pipeline: numerator, norm, restoring root search and result register
module edc_back
   import edc_pkg::*;
#(
   parameter int COEF_WIDTH = CoefWidthDefault,
   parameter int FRAC_BITS  = FracBitsDefault,
   parameter int LW         = COEF_WIDTH + PointWidth + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  logic [3*LW+2*PointWidth-1:0] q_data,
   output logic                         q_pop,
   input  logic [DistWidth-1:0]         dist_limit,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output edc_rsp_type                  rsp_data
);

   localparam int PW3 = LW + PointWidth + 1;
   localparam int NW  = LW + PointWidth + 2;
   localparam int HA  = (LW + 1) / 2;
   localparam int HN  = (NW + 1) / 2;
   localparam int SW  = 2 * LW + 1;
   localparam int DW  = RootWidth;
   localparam int TW  = SW + DW;
   localparam int XW  = ((2 * NW > SW + 2 * DW) ? 2 * NW : SW + 2 * DW) + 2;

   logic adv;
   logic b1_vld_ff, b2_vld_ff, b3_vld_ff, out_vld_ff;

   // stage 1: second point against the line
   logic signed [LW-1:0]  qa, qb, qc;
   logic [PointWidth-1:0] qx2, qy2;
   logic signed [PW3-1:0] px_ff, py_ff;
   logic signed [LW-1:0]  c_ff;
   logic [LW-1:0]         mag_a_ff, mag_b_ff;
   logic                  degen_b1_ff;

   // stage 2: numerator and square partials of a and b
   logic [NW-1:0]         mag_n_ff;
   logic [2*HA-1:0]       aa_ll_ff, bb_ll_ff;
   logic [LW-1:0]         aa_hl_ff, bb_hl_ff;
   logic [2*(LW-HA)-1:0]  aa_hh_ff, bb_hh_ff;
   logic                  degen_b2_ff, dg_sat_b2_ff;
   logic [DistWidth-1:0]  dg_val_b2_ff;
   logic signed [NW-1:0]  n_in;
   logic [NW-1:0]         mag_n_in, dg_in;

   // stage 3: norm squared and numerator square partials
   logic [SW-1:0]         s_b3_ff;
   logic [2*HN-1:0]       nn_ll_ff;
   logic [NW-1:0]         nn_hl_ff;
   logic [2*(NW-HN)-1:0]  nn_hh_ff;
   logic                  degen_b3_ff, dg_sat_b3_ff;
   logic [DistWidth-1:0]  dg_val_b3_ff;

   // root search stages, index 0 is the start value
   logic [XW-1:0]        rr_ff [DW+1];
   logic [TW-1:0]        tt_ff [DW+1];
   logic [SW-1:0]        ss_ff [DW+1];
   logic [DW-1:0]        dd_ff [DW+1];
   logic [DW:0]          rv_ff;
   logic                 rdeg_ff [DW+1];
   logic                 rsat_ff [DW+1];
   logic [DistWidth-1:0] rdg_ff  [DW+1];

   edc_rsp_type          rsp_ff, rsp_in;

   assign adv       = !(out_vld_ff && !rsp_pop);
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = rsp_ff;
   assign {qa, qb, qc, qx2, qy2} = q_data;

   assign n_in     = NW'(px_ff) + NW'(py_ff) + (NW'(c_ff) <<< FRAC_BITS);
   assign mag_n_in = n_in[NW-1] ? NW'(-n_in) : NW'(n_in);
   assign dg_in    = mag_n_in >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff <= !q_empty;
         b2_vld_ff <= b1_vld_ff;
         b3_vld_ff <= b2_vld_ff;
      end
      if (adv) begin
         px_ff       <= PW3'(qa) * PW3'(signed'({1'b0, qx2}));
         py_ff       <= PW3'(qb) * PW3'(signed'({1'b0, qy2}));
         c_ff        <= qc;
         mag_a_ff    <= qa[LW-1] ? LW'(-qa) : LW'(qa);
         mag_b_ff    <= qb[LW-1] ? LW'(-qb) : LW'(qb);
         degen_b1_ff <= (qa == '0) && (qb == '0);

         mag_n_ff     <= mag_n_in;
         aa_ll_ff     <= (2*HA)'(mag_a_ff[HA-1:0]) * (2*HA)'(mag_a_ff[HA-1:0]);
         aa_hl_ff     <= LW'(mag_a_ff[LW-1:HA]) * LW'(mag_a_ff[HA-1:0]);
         aa_hh_ff     <= (2*(LW-HA))'(mag_a_ff[LW-1:HA]) * (2*(LW-HA))'(mag_a_ff[LW-1:HA]);
         bb_ll_ff     <= (2*HA)'(mag_b_ff[HA-1:0]) * (2*HA)'(mag_b_ff[HA-1:0]);
         bb_hl_ff     <= LW'(mag_b_ff[LW-1:HA]) * LW'(mag_b_ff[HA-1:0]);
         bb_hh_ff     <= (2*(LW-HA))'(mag_b_ff[LW-1:HA]) * (2*(LW-HA))'(mag_b_ff[LW-1:HA]);
         degen_b2_ff  <= degen_b1_ff;
         dg_sat_b2_ff <= |dg_in[NW-1:DistWidth];
         dg_val_b2_ff <= dg_in[DistWidth-1:0];

         s_b3_ff      <= (SW'(aa_hh_ff) << (2*HA)) + (SW'(aa_hl_ff) << (HA+1)) + SW'(aa_ll_ff)
                       + (SW'(bb_hh_ff) << (2*HA)) + (SW'(bb_hl_ff) << (HA+1)) + SW'(bb_ll_ff);
         nn_ll_ff     <= (2*HN)'(mag_n_ff[HN-1:0]) * (2*HN)'(mag_n_ff[HN-1:0]);
         nn_hl_ff     <= NW'(mag_n_ff[NW-1:HN]) * NW'(mag_n_ff[HN-1:0]);
         nn_hh_ff     <= (2*(NW-HN))'(mag_n_ff[NW-1:HN]) * (2*(NW-HN))'(mag_n_ff[NW-1:HN]);
         degen_b3_ff  <= degen_b2_ff;
         dg_sat_b3_ff <= dg_sat_b2_ff;
         dg_val_b3_ff <= dg_val_b2_ff;
      end
   end

   // start of the root search: remainder is the numerator squared
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (adv) begin
         rv_ff[0] <= b3_vld_ff;
      end
      if (adv) begin
         rr_ff[0]   <= (XW'(nn_hh_ff) << (2*HN)) + (XW'(nn_hl_ff) << (HN+1)) + XW'(nn_ll_ff);
         tt_ff[0]   <= '0;
         ss_ff[0]   <= s_b3_ff;
         dd_ff[0]   <= '0;
         rdeg_ff[0] <= degen_b3_ff;
         rsat_ff[0] <= dg_sat_b3_ff;
         rdg_ff[0]  <= dg_val_b3_ff;
      end
   end

   // one result bit per stage: keep d^2 * s <= n^2 with t tracking d * s
   for (genvar j = 0; j < DW; j++) begin : g_root
      localparam int K = DW - 1 - j;
      logic [XW-1:0] cand_in, rr_in;
      logic [TW-1:0] tt_in;
      logic [DW-1:0] dd_in;
      always_comb begin
         cand_in = (XW'(tt_ff[j]) << (K + 1)) + (XW'(ss_ff[j]) << (2 * K));
         rr_in   = rr_ff[j];
         tt_in   = tt_ff[j];
         dd_in   = dd_ff[j];
         if (rr_ff[j] >= cand_in) begin
            rr_in = rr_ff[j] - cand_in;
            tt_in = tt_ff[j] + (TW'(ss_ff[j]) << K);
            dd_in = dd_ff[j] | (DW'(1) << K);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            rv_ff[j+1] <= rv_ff[j];
         end
         if (adv) begin
            rr_ff[j+1]   <= rr_in;
            tt_ff[j+1]   <= tt_in;
            ss_ff[j+1]   <= ss_ff[j];
            dd_ff[j+1]   <= dd_in;
            rdeg_ff[j+1] <= rdeg_ff[j];
            rsat_ff[j+1] <= rsat_ff[j];
            rdg_ff[j+1]  <= rdg_ff[j];
         end
      end
   end

   always_comb begin
      logic sat;
      logic [DistWidth-1:0] dist_val;
      sat      = rdeg_ff[DW] ? rsat_ff[DW] : dd_ff[DW][DW-1];
      dist_val = rdeg_ff[DW] ? rdg_ff[DW] : dd_ff[DW][DistWidth-1:0];
      if (sat) begin
         dist_val = '1;
      end
      rsp_in.line_distance = dist_val;
      rsp_in.on_line       = !sat && (dist_val <= dist_limit);
      rsp_in.degenerate    = rdeg_ff[DW];
      rsp_in.saturated     = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= rv_ff[DW];
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

`include "epipolar_distance_check_assert.svh"
   `EDC_ASSERT_NEXT(a_out_hold, clock, reset, out_vld_ff && !rsp_pop, out_vld_ff && $stable(rsp_ff))
   `EDC_ASSERT_IMP(a_sat_clamp, clock, reset, out_vld_ff && rsp_ff.saturated, (rsp_ff.line_distance == '1) && !rsp_ff.on_line)

endmodule

### src/epipolar_distance_check.sv
// Epipolar distance check, top level: csr registers, front end, queue, distance pipeline.
// Takes one point correspondence per clock and returns one result per correspondence, in
// order. From a req transfer to the result on the rsp side, the data passes the two
// front-end stages forming the epipolar line (the transfer edge loads the first), then
// one queue slot, four stages for the numerator and the squared norm, seventeen stages
// of the restoring root search (one result bit per stage), and the result register.
// The rate of one per cycle is held as long as rsp_pop keeps up; when the result side
// stalls, the four-entry queue and the front end keep taking transfers until they fill.
// The matrix rows and the distance limit are written through the csr port and must only
// change while the block is idle.
module epipolar_distance_check
   import edc_pkg::*;
#(
   parameter int COEF_WIDTH = CoefWidthDefault,
   parameter int FRAC_BITS  = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  edc_req_type              req_data,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output edc_rsp_type              rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RowWidth-1:0]      csr_wr_data
);

   localparam int LW = COEF_WIDTH + PointWidth + 2;
   localparam int QW = 3 * LW + 2 * PointWidth;

   logic [2:0][RowWidth-1:0] row_ff;
   logic [DistWidth-1:0]     limit_ff;
   logic                     q_full, q_push, q_empty, q_pop;
   logic [QW-1:0]            q_wr_data, q_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         limit_ff <= DistLimitReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_ZERO:   row_ff[0] <= csr_wr_data;
            CSR_ROW_ONE:    row_ff[1] <= csr_wr_data;
            CSR_ROW_TWO:    row_ff[2] <= csr_wr_data;
            CSR_DIST_LIMIT: limit_ff  <= csr_wr_data[DistWidth-1:0];
            default:        limit_ff  <= limit_ff;
         endcase
      end
   end

   edc_front #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .LW         (LW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .rows     (row_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   edc_queue #(
      .WIDTH (QW),
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   edc_back #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .LW         (LW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_rd_data),
      .q_pop      (q_pop),
      .dist_limit (limit_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
